FILE: rtl/lpl_pkg.sv
package lpl_pkg;
    localparam int unsigned CfgAddrBits = 4;
    localparam logic [1:0] RegGate    = 2'd0;
    localparam logic [1:0] RegAttack  = 2'd1;
    localparam logic [1:0] RegRelease = 2'd2;

    typedef struct packed {
        logic start;
        logic busy;
    } t_div_ctl;
endpackage

FILE: rtl/lpl_div.sv
module lpl_div
    import lpl_pkg::*;
#(
    parameter int unsigned W = 24
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output t_div_ctl     o_ctl,
    output logic [W-1:0] o_quot
);
    // restoring divide of (num << (W-1)) by den, one quotient bit a cycle
    localparam int unsigned NB = 2 * W - 1;
    localparam int unsigned CB = $clog2(NB + 1);

    logic [NB-1:0] r_num;
    logic [W:0]    r_rem;
    logic [W-1:0]  r_den;
    logic [W-1:0]  r_q;
    logic [CB-1:0] r_cnt;
    logic          r_busy;
    logic [W:0]    w_sh;
    logic [W+1:0]  w_diff;

    assign w_sh   = {r_rem[W-1:0], r_num[NB-1]};
    assign w_diff = {1'b0, w_sh} - {2'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_num  <= {i_num, {(W-1){1'b0}}};
            r_rem  <= '0;
            r_den  <= i_den;
            r_cnt  <= CB'(NB);
        end else if (r_busy) begin
            r_num <= {r_num[NB-2:0], 1'b0};
            if (!w_diff[W+1]) begin
                r_rem <= w_diff[W:0];
                r_q   <= {r_q[W-2:0], 1'b1};
            end else begin
                r_rem <= w_sh;
                r_q   <= {r_q[W-2:0], 1'b0};
            end
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CB'(1)) r_busy <= 1'b0;
        end
    end

    assign o_ctl.start = i_start;
    assign o_ctl.busy  = r_busy;
    assign o_quot      = r_q;
endmodule

FILE: rtl/lookahead_peak_limiter.sv
// channel | direction | signals
// sample  | in        | i_sample_in_valid/o_sample_in_ready, i_sample_in
// result  | out       | o_result_valid/i_result_ready, o_sample_out, o_gain_now
// cfg     | in        | APB psel/penable/pwrite/paddr/pwdata, prdata, pready
// A sample walks the tree from its leaf to the root, reading the sibling and writing the
// parent at each level; when the peak is above the gate the bit-serial divider runs next,
// else the divide is skipped. After reset a clearing pass zeroes both memories; no sample
// is taken meanwhile. A waiting result does not block the next sample; that one holds in
// its last step until the result register is free.
module lookahead_peak_limiter
    import lpl_pkg::*;
#(
    parameter int unsigned WINDOW      = 256,
    parameter int unsigned SAMPLE_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_sample_in_valid,
    output logic                          o_sample_in_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_in,
    output logic                          o_result_valid,
    input  logic                          i_result_ready,
    output logic signed [SAMPLE_BITS-1:0] o_sample_out,
    output logic        [SAMPLE_BITS-1:0] o_gain_now,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [CfgAddrBits-1:0]        paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    localparam int unsigned W  = SAMPLE_BITS;
    localparam int unsigned F  = W - 1;
    localparam int unsigned AB = $clog2(WINDOW);
    localparam int unsigned TB = AB + 1;
    localparam logic [W-1:0] Unity = W'(1) << F;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_RDSIB, S_WAIT, S_UPD, S_DIV, S_DIVW, S_ENV, S_MUL, S_OUT
    } t_state;

    t_state r_state;
    logic [W-1:0] r_gate, r_att, r_rel, r_env;
    logic [AB-1:0] r_wp;
    logic [TB:0]   r_clr;
    logic [TB-1:0] r_node;
    logic [W-1:0]  r_cur, r_target, r_peak;
    logic signed [W-1:0] r_samp, r_dly;
    logic signed [2*W:0] r_prod;
    logic r_ovalid;
    logic signed [W-1:0] r_oval;
    logic [W-1:0] r_ogain;

    // memories
    logic [W-1:0] m_tree [2*WINDOW];
    logic [W-1:0] m_dly  [WINDOW];
    logic [W-1:0] r_tq, r_dq;
    logic         tree_we, d_we;
    logic [TB-1:0] tree_wa, tree_ra;
    logic [W-1:0]  tree_wd;
    logic [AB-1:0] d_a;
    logic [W-1:0]  d_wd;

    always_ff @(posedge i_clk) begin
        if (tree_we) m_tree[tree_wa] <= tree_wd;
        r_tq <= m_tree[tree_ra];
    end
    always_ff @(posedge i_clk) begin
        if (d_we) m_dly[d_a] <= d_wd;
        r_dq <= m_dly[d_a];
    end

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    always_comb begin
        case (paddr[CfgAddrBits-1:2])
            2'(RegGate):    prdata = 32'(r_gate);
            2'(RegAttack):  prdata = 32'(r_att);
            2'(RegRelease): prdata = 32'(r_rel);
            default:        prdata = '0;
        endcase
    end

    logic [W-1:0] w_mag, w_max, w_sat_a, w_sat_r, w_diffv;
    logic [2*W-1:0] w_step;
    logic [W:0] w_up;
    logic w_fall;
    assign w_mag   = i_sample_in[W-1] ? W'(-i_sample_in) : W'(i_sample_in);
    assign w_max   = (r_tq > r_cur) ? r_tq : r_cur;
    assign w_sat_a = (r_att > Unity) ? Unity : r_att;
    assign w_sat_r = (r_rel > Unity) ? Unity : r_rel;
    assign w_fall  = r_target < r_env;
    assign w_diffv = w_fall ? r_env - r_target : r_target - r_env;
    assign w_step  = (w_fall ? w_sat_a : w_sat_r) * w_diffv;
    assign w_up    = {1'b0, r_env} + (W+1)'(w_step >> F);

    t_div_ctl div_ctl;
    logic [W-1:0] div_q;
    lpl_div #(.W(W)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_state == S_DIV),
        .i_num(r_gate), .i_den(r_peak), .o_ctl(div_ctl), .o_quot(div_q)
    );

    logic w_acc;
    assign o_sample_in_ready = (r_state == S_IDLE);
    assign w_acc = i_sample_in_valid && o_sample_in_ready;

    always_comb begin
        tree_we = 1'b0; tree_wa = r_node; tree_wd = r_cur; tree_ra = r_node ^ TB'(1);
        d_we = 1'b0; d_a = r_wp; d_wd = W'(i_sample_in);
        case (r_state)
            S_CLR: begin
                tree_we = 1'b1; tree_wa = r_clr[TB-1:0]; tree_wd = '0;
                d_we = 1'b1; d_a = r_clr[AB-1:0]; d_wd = '0;
            end
            S_IDLE: begin
                tree_we = w_acc; tree_wa = TB'(WINDOW) + TB'(r_wp); tree_wd = w_mag;
                d_we = w_acc;
            end
            S_UPD: begin
                tree_we = 1'b1; tree_wa = r_node >> 1; tree_wd = w_max;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_gate   <= Unity;
            r_att    <= W'(34900);
            r_rel    <= W'(2184);
            r_env    <= Unity;
            r_wp     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (paddr[CfgAddrBits-1:2])
                    2'(RegGate):    r_gate <= pwdata[W-1:0];
                    2'(RegAttack):  r_att  <= pwdata[W-1:0];
                    2'(RegRelease): r_rel  <= pwdata[W-1:0];
                    default: ;
                endcase
            end
            if (r_ovalid && i_result_ready) r_ovalid <= 1'b0;
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (TB+1)'(2*WINDOW-1)) r_state <= S_IDLE;
                end
                S_IDLE: if (w_acc) begin
                    r_samp  <= i_sample_in;
                    r_cur   <= w_mag;
                    r_node  <= TB'(WINDOW) + TB'(r_wp);
                    r_wp    <= (r_wp == AB'(WINDOW-1)) ? '0 : r_wp + 1'b1;
                    r_state <= S_RDSIB;
                end
                S_RDSIB: begin
                    r_dly   <= r_dq;   // old delay entry, read during accept
                    r_state <= S_WAIT;
                end
                S_WAIT: r_state <= S_UPD;
                S_UPD: begin
                    r_cur  <= w_max;
                    r_node <= r_node >> 1;
                    if ((r_node >> 1) == TB'(1)) begin
                        r_peak  <= w_max;
                        r_state <= (w_max > r_gate) ? S_DIV : S_ENV;
                        r_target <= Unity;
                    end else begin
                        r_state <= S_WAIT;
                    end
                end
                S_DIV: r_state <= S_DIVW;
                S_DIVW: if (!div_ctl.busy) begin
                    r_target <= div_q;
                    r_state  <= S_ENV;
                end
                S_ENV: begin
                    if (w_fall) r_env <= r_env - W'(w_step >> F);
                    else r_env <= (w_up > (W+1)'(Unity)) ? Unity : w_up[W-1:0];
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= (2*W+1)'(r_dly) * $signed({1'b0, r_env});
                    r_state <= S_OUT;
                end
                S_OUT: if (!r_ovalid) begin
                    // arithmetic shift rounds towards minus infinity
                    r_oval   <= r_prod[W+F-1:F];
                    r_ogain  <= r_env;
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_result_valid = r_ovalid;
    assign o_sample_out   = r_oval;
    assign o_gain_now     = r_ogain;

    a_env_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_env <= Unity) else $error("envelope above unity");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> r_state == S_RDSIB) else $error("accept did not start walk");
    a_div_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_ctl.busy |-> r_state == S_DIVW) else $error("divider busy out of turn");
endmodule
